>>> rtl/dfu_pkg.sv
// ----------------------------------------------------------------------------
// dfu_pkg
// Shared types and constants for the flag frame deframer and unescaper.
// ----------------------------------------------------------------------------
package dfu_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;

    localparam int DEF_MAX_FRAME_BYTES = 1024;

    // Depth of the command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Configuration register map.
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_ESCAPE_BASE = 1'b0;
    localparam logic        ESCAPE_BASE_RST = 1'b1;

    // One command per input byte that causes results. With two_beats set the
    // back part first sends an escape byte and then the command's data byte.
    typedef struct packed {
        logic [7:0] data;
        logic       two_beats;
        logic       has_byte;
        logic       end_of_frame;
        logic       overflow_error;
    } t_cmd;

endpackage

>>> rtl/dfu_front.sv
// ----------------------------------------------------------------------------
// dfu_front
// Frame hunting, escape tracking and length check; at most one command per byte.
// ----------------------------------------------------------------------------
module dfu_front #(
    parameter int MAX_FRAME_BYTES = dfu_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte_in,
    input  logic          i_escape_base,
    output logic          o_cmd_valid,
    output dfu_pkg::t_cmd o_cmd
);

    localparam int             CntW   = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME_BYTES);
    localparam logic [CntW-1:0] OneCnt = CntW'(1);

    logic            r_inside, n_inside;
    logic            r_esc, n_esc;
    logic [CntW-1:0] r_cnt, n_cnt;

    logic            is_flag;
    logic [7:0]      base_code;
    logic [7:0]      base_next;

    assign is_flag   = (i_byte_in == dfu_pkg::FLAG_BYTE);
    assign base_code = {7'b0, i_escape_base};
    assign base_next = base_code + 8'd1;

    always_comb begin
        n_inside    = r_inside;
        n_esc       = r_esc;
        n_cnt       = r_cnt;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            if (!r_inside) begin
                if (is_flag) begin
                    n_inside = 1'b1;
                    n_esc    = 1'b0;
                    n_cnt    = OneCnt;
                end
            end else if (is_flag && (r_cnt <= OneCnt)) begin
                // A flag straight after the opening flag opens the frame anew.
                n_esc = 1'b0;
                n_cnt = OneCnt;
            end else if (r_cnt >= MaxCnt) begin
                n_inside             = 1'b0;
                n_esc                = 1'b0;
                n_cnt                = '0;
                o_cmd_valid          = 1'b1;
                o_cmd.overflow_error = 1'b1;
            end else begin
                n_cnt = r_cnt + OneCnt;
                if (is_flag) begin
                    // A dangling escape before the closing flag is kept.
                    o_cmd_valid        = 1'b1;
                    o_cmd.end_of_frame = 1'b1;
                    o_cmd.has_byte     = r_esc;
                    o_cmd.data         = r_esc ? dfu_pkg::ESC_BYTE : 8'h00;
                    n_inside           = 1'b0;
                    n_esc              = 1'b0;
                    n_cnt              = '0;
                end else if (r_esc) begin
                    n_esc          = 1'b0;
                    o_cmd_valid    = 1'b1;
                    o_cmd.has_byte = 1'b1;
                    if (i_byte_in == base_code) begin
                        o_cmd.data = dfu_pkg::ESC_BYTE;
                    end else if (i_byte_in == base_next) begin
                        o_cmd.data = dfu_pkg::FLAG_BYTE;
                    end else begin
                        o_cmd.data      = i_byte_in;
                        o_cmd.two_beats = 1'b1;
                    end
                end else if (i_byte_in == dfu_pkg::ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    o_cmd_valid    = 1'b1;
                    o_cmd.has_byte = 1'b1;
                    o_cmd.data     = i_byte_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_esc    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_inside <= n_inside;
            r_esc    <= n_esc;
            r_cnt    <= n_cnt;
        end
    end

endmodule

>>> rtl/dfu_cmdq.sv
// ----------------------------------------------------------------------------
// dfu_cmdq
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module dfu_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  dfu_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd,
    output dfu_pkg::t_cmd o_rd_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam logic [dfu_pkg::CMDQ_CNT_W-1:0] Depth =
        dfu_pkg::CMDQ_CNT_W'(dfu_pkg::CMDQ_DEPTH);

    dfu_pkg::t_cmd                    r_mem [dfu_pkg::CMDQ_DEPTH];
    logic [dfu_pkg::CMDQ_PTR_W-1:0]   r_wp, r_rp;
    logic [dfu_pkg::CMDQ_CNT_W-1:0]   r_cnt;
    logic                             do_wr, do_rd;

    assign o_full   = (r_cnt == Depth);
    assign o_empty  = (r_cnt == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/dfu_back.sv
// ----------------------------------------------------------------------------
// dfu_back
// Expands queued commands into result beats held in an output register.
// ----------------------------------------------------------------------------
module dfu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dfu_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_byte_out,
    output logic          o_has_byte,
    output logic          o_end_of_frame,
    output logic          o_overflow_error,
    output logic          o_last_in_run
);

    logic          r_valid;
    logic          r_second;
    dfu_pkg::t_cmd r_cmd;
    logic          first_of_two;
    logic          taken;
    logic          done;

    assign first_of_two = r_cmd.two_beats && !r_second;
    assign taken        = r_valid && i_pop;
    assign done         = taken && !first_of_two;
    // The register is free for the next command when empty or finishing.
    assign o_cmd_rd     = !i_cmd_empty && (!r_valid || done);

    assign o_empty          = !r_valid;
    assign o_byte_out       = first_of_two ? dfu_pkg::ESC_BYTE : r_cmd.data;
    assign o_has_byte       = r_cmd.has_byte;
    assign o_end_of_frame   = r_cmd.end_of_frame;
    assign o_overflow_error = r_cmd.overflow_error;
    assign o_last_in_run    = !first_of_two;

    always_ff @(posedge i_clk) begin
        if (o_cmd_rd) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (o_cmd_rd) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else if (done) begin
                r_valid  <= 1'b0;
                r_second <= 1'b0;
            end else if (taken) begin
                r_second <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/flag_frame_deframer_unescape_top.sv
// ----------------------------------------------------------------------------
// flag_frame_deframer_unescape_top
// Finds 0x7E delimited frames in a byte stream, undoes 0x7D escaping and
// streams payload bytes with end of frame and overflow markers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// input     in         i_push / o_full        i_byte_in
// result    out        o_empty / i_pop        o_byte_out, o_has_byte,
//                                             o_end_of_frame, o_overflow_error,
//                                             o_last_in_run
// config    in         APB psel/penable/...   escape_base at byte address 0
//
// One input byte is taken every cycle while the command queue has room; the
// result side delivers one beat per cycle while i_pop is high, so a byte that
// yields two results occupies the output register until both beats are popped.
// A result reaches the ports after its byte is accepted by way of two registers:
// first the command queue and then the output register.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module flag_frame_deframer_unescape_top #(
    parameter int MAX_FRAME_BYTES = dfu_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [7:0]                    i_byte_in,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [7:0]                    o_byte_out,
    output logic                          o_has_byte,
    output logic                          o_end_of_frame,
    output logic                          o_overflow_error,
    output logic                          o_last_in_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic          r_escape_base;
    logic          cfg_wr;
    logic          accept;
    logic          cmd_valid;
    dfu_pkg::t_cmd cmd_wr;
    dfu_pkg::t_cmd cmd_rd;
    logic          cmdq_rd;
    logic          cmdq_empty;
    logic          cmdq_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dfu_pkg::REG_ESCAPE_BASE) ? {31'b0, r_escape_base} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_base <= dfu_pkg::ESCAPE_BASE_RST;
        end else if (cfg_wr && (paddr[2] == dfu_pkg::REG_ESCAPE_BASE)) begin
            r_escape_base <= pwdata[0];
        end
    end

    assign o_full = cmdq_full;
    assign accept = i_push && !cmdq_full;

    dfu_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte_in     (i_byte_in),
        .i_escape_base (r_escape_base),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd_wr)
    );

    dfu_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd_wr),
        .i_rd     (cmdq_rd),
        .o_rd_cmd (cmd_rd),
        .o_full   (cmdq_full),
        .o_empty  (cmdq_empty)
    );

    dfu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd_rd),
        .i_cmd_empty      (cmdq_empty),
        .o_cmd_rd         (cmdq_rd),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_byte_out       (o_byte_out),
        .o_has_byte       (o_has_byte),
        .o_end_of_frame   (o_end_of_frame),
        .o_overflow_error (o_overflow_error),
        .o_last_in_run    (o_last_in_run)
    );

endmodule
